// ===== rtl/pai_pkg.sv =====
package pai_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned PosW     = 5;
  localparam int unsigned FillW    = 5;
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned StatW    = 2;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    logic              ins;
    logic [CmpW-1:0]   pos;
    data_t             value;
  } op_t;

endpackage

// ===== rtl/pai_front.sv =====
module pai_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [pai_pkg::PosW-1:0]  position_i,
  input  logic signed [31:0]        value_i,
  output logic                      op_valid_o,
  input  logic                      op_ready_i,
  output pai_pkg::op_t              op_o
);
  import pai_pkg::*;

  logic valid_q;
  op_t  op_q;
  op_t  op_d;

  always_comb begin
    op_d.ins   = (action_e'(action_i) == ACT_INSERT);
    op_d.pos   = CmpW'(position_i);
    op_d.value = value_i;
  end

  assign in_ready_o = !valid_q || op_ready_i;
  assign op_valid_o = valid_q;
  assign op_o       = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= op_d;
    end
  end

endmodule

// ===== rtl/pai_queue.sv =====
module pai_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  pai_pkg::op_t wr_op_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output pai_pkg::op_t rd_op_o
);
  import pai_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_op_o    = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

// ===== rtl/pai_back.sv =====
module pai_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  pai_pkg::op_t                  op_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pai_pkg::StatW-1:0]     status_o,
  output logic [pai_pkg::FillW-1:0]     fill_count_o,
  output logic [pai_pkg::SlotIdxW-1:0]  slot_index_o,
  output logic signed [31:0]            slot_value_o,
  output logic                          last_o
);
  import pai_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e          state_q;
  data_t           slots_q [Capacity];
  data_t           slots_d [Capacity];
  data_t           up     [Capacity];
  data_t           dn     [Capacity];
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [IdxW-1:0] k_q;
  status_e         stat_d;
  status_e         stat_q;
  logic [CmpW-1:0] count_ext;
  logic            k_last;

  logic                out_valid_q;
  logic [StatW-1:0]    status_q;
  logic [FillW-1:0]    fill_q;
  logic [SlotIdxW-1:0] idx_q;
  data_t               val_q;
  logic                last_q;

  assign count_ext  = CmpW'(count_q);
  assign k_last     = (k_q == IdxW'(Capacity - 1));
  assign op_ready_o = (state_q == S_IDLE);

  always_comb begin
    up[0]          = '0;
    dn[Capacity-1] = '0;
    for (int i = 1; i < Capacity; i++) begin
      up[i] = slots_q[i-1];
    end
    for (int i = 0; i < Capacity - 1; i++) begin
      dn[i] = slots_q[i+1];
    end

    stat_d  = STAT_DONE;
    count_d = count_q;
    if (op_i.ins) begin
      if (count_q >= CntW'(Capacity)) begin
        stat_d = STAT_FULL;
      end else if (op_i.pos > count_ext) begin
        stat_d = STAT_RANGE;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (op_i.pos >= count_ext) begin
        stat_d = STAT_RANGE;
      end else begin
        count_d = count_q - 1'b1;
      end
    end

    for (int i = 0; i < Capacity; i++) begin
      if (stat_d != STAT_DONE) begin
        slots_d[i] = slots_q[i];
      end else if (op_i.ins) begin
        if (CmpW'(i) > op_i.pos) begin
          slots_d[i] = up[i];
        end else if (CmpW'(i) == op_i.pos) begin
          slots_d[i] = op_i.value;
        end else begin
          slots_d[i] = slots_q[i];
        end
      end else begin
        slots_d[i] = (CmpW'(i) >= op_i.pos) ? dn[i] : slots_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      stat_q      <= STAT_DONE;
      out_valid_q <= 1'b0;
      status_q    <= STAT_DONE;
      fill_q      <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      last_q      <= 1'b0;
      for (int i = 0; i < Capacity; i++) begin
        slots_q[i] <= '0;
      end
    end else begin
      if (state_q == S_READ && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            stat_q  <= stat_d;
            count_q <= count_d;
            slots_q <= slots_d;
            k_q     <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (!out_valid_q || out_ready_i) begin
            status_q <= stat_q;
            fill_q   <= FillW'(count_q);
            idx_q    <= SlotIdxW'(k_q);
            val_q    <= slots_q[k_q];
            last_q   <= k_last;
            k_q      <= k_q + 1'b1;
            if (k_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;
  assign slot_index_o = idx_q;
  assign slot_value_o = val_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/positional_array_insert_delete.sv =====
// Ordered store of 16 signed 32-bit entries with insert and delete at a 0-based
// position. Every input transaction, successful or not, yields a readout of all
// 16 slots in index order on the output channel, each carrying the status and the
// fill count after the operation, with last_o set on slot 15. Unused slots read
// zero. An operation occupies the execution unit for its update in the idle state
// and then for the readout, one slot per cycle while the receiver is ready
// (out_ready_i); the input register and a two-entry queue let up to three further
// transactions be taken in meanwhile. The store is cleared by reset.
module positional_array_insert_delete (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [pai_pkg::PosW-1:0]      position_i,
  input  logic signed [31:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pai_pkg::StatW-1:0]     status_o,
  output logic [pai_pkg::FillW-1:0]     fill_count_o,
  output logic [pai_pkg::SlotIdxW-1:0]  slot_index_o,
  output logic signed [31:0]            slot_value_o,
  output logic                          last_o
);
  import pai_pkg::*;

  logic f_valid;
  logic f_ready;
  op_t  f_op;
  logic b_valid;
  logic b_ready;
  op_t  b_op;

  pai_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  pai_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_op_i    (f_op),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_op_o    (b_op)
  );

  pai_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (b_valid),
    .op_ready_o   (b_ready),
    .op_i         (b_op),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .fill_count_o (fill_count_o),
    .slot_index_o (slot_index_o),
    .slot_value_o (slot_value_o),
    .last_o       (last_o)
  );

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (slot_index_o == SlotIdxW'(Capacity - 1))))
    else $error("last flag out of step with slot index");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o <= FillW'(Capacity)))
    else $error("fill count above capacity");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_DONE || status_o == STAT_FULL ||
                     status_o == STAT_RANGE))
    else $error("bad status code");

  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (out_valid_o && slot_index_o == $past(slot_index_o) + 1'b1 &&
       fill_count_o == $past(fill_count_o)))
    else $error("readout run broken");

endmodule

// ===== tb/sv/positional_array_insert_delete_test.sv =====
`timescale 1ns / 1ps

module positional_array_insert_delete_test;
  import pai_pkg::*;

  typedef struct {
    status_e              status;
    logic [FillW-1:0]     fill;
    logic [SlotIdxW-1:0]  idx;
    data_t                value;
    logic                 last;
  } readout_t;

  class readout_scoreboard;
    data_t       store [Capacity];
    int unsigned count;
    readout_t    expected_readout [$];
    int unsigned errors;

    function new();
      foreach (store[i]) store[i] = '0;
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_readout.size();
    endfunction

    task flag_mismatch(input string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    // accepted transaction: apply the operation, queue the full readout
    function void note_op(input action_e act, input logic [PosW-1:0] pos,
                          input data_t val);
      status_e     st;
      int unsigned p;
      int unsigned i;
      readout_t    r;
      p = pos;
      if (act == ACT_INSERT) begin
        if (count >= Capacity) begin
          st = STAT_FULL;
        end else if (p > count) begin
          st = STAT_RANGE;
        end else begin
          for (i = count; i > p; i--) store[i] = store[i-1];
          store[p] = val;
          count++;
          st = STAT_DONE;
        end
      end else begin
        if (p >= count) begin
          st = STAT_RANGE;
        end else begin
          for (i = p; i + 1 < count; i++) store[i] = store[i+1];
          count--;
          store[count] = '0;
          st = STAT_DONE;
        end
      end
      for (i = 0; i < Capacity; i++) begin
        r.status = st;
        r.fill   = count[FillW-1:0];
        r.idx    = i[SlotIdxW-1:0];
        r.value  = store[i];
        r.last   = (i == Capacity - 1);
        expected_readout.push_back(r);
      end
    endfunction

    task check_slot(input logic [StatW-1:0] status, input logic [FillW-1:0] fill,
                    input logic [SlotIdxW-1:0] idx, input data_t value,
                    input logic last);
      readout_t e;
      if (expected_readout.size() == 0) begin
        flag_mismatch($sformatf("readout slot %0d with nothing expected", idx));
      end else begin
        e = expected_readout.pop_front();
        if (status !== e.status)
          flag_mismatch($sformatf("slot %0d status %0d, want %0d", e.idx, status, e.status));
        if (fill !== e.fill)
          flag_mismatch($sformatf("slot %0d fill %0d, want %0d", e.idx, fill, e.fill));
        if (idx !== e.idx)
          flag_mismatch($sformatf("slot index %0d, want %0d", idx, e.idx));
        if (value !== e.value)
          flag_mismatch($sformatf("slot %0d value %h, want %h", e.idx, value, e.value));
        if (last !== e.last)
          flag_mismatch($sformatf("slot %0d last %b, want %b", e.idx, last, e.last));
      end
    endtask
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 action_i    = 1'b0;
  logic [PosW-1:0]      position_i  = '0;
  logic signed [31:0]   value_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [StatW-1:0]     status_o;
  logic [FillW-1:0]     fill_count_o;
  logic [SlotIdxW-1:0]  slot_index_o;
  logic signed [31:0]   slot_value_o;
  logic                 last_o;

  readout_scoreboard sb = new();
  int unsigned       cycle_cnt = 0;
  bit                sender_calm = 1'b0;

  positional_array_insert_delete u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .fill_count_o (fill_count_o),
    .slot_index_o (slot_index_o),
    .slot_value_o (slot_value_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random back-pressure, calm window with none
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_slot(status_o, fill_count_o, slot_index_o, slot_value_o, last_o);
    if (cycle_cnt > 1500 && cycle_cnt < 3000) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 15);
  end

  task send_op(input action_e act, input logic [PosW-1:0] pos, input data_t val);
    if (!sender_calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(act, pos, val);
  endtask

  task drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function data_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    int unsigned c;
    bit grow;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_op(ACT_DELETE, 5'd0, 32'sd7);
    send_op(ACT_INSERT, 5'd31, 32'sd9);
    send_op(ACT_INSERT, 5'd0, 32'sh8000_0000);
    send_op(ACT_INSERT, 5'd1, 32'sh7fff_ffff);
    send_op(ACT_INSERT, 5'd0, -32'sd1);
    send_op(ACT_INSERT, 5'd1, 32'sh5555_5555);
    send_op(ACT_DELETE, 5'd4, 32'sd0);
    send_op(ACT_DELETE, 5'd1, 32'sd0);
    send_op(ACT_DELETE, 5'd2, 32'sd0);
    while (sb.count < Capacity) begin
      c = sb.count;
      send_op(ACT_INSERT, (c % 2) ? 5'd0 : c[PosW-1:0], $urandom);
    end
    send_op(ACT_INSERT, 5'd0, 32'sd1);
    send_op(ACT_INSERT, 5'd16, 32'sd2);
    send_op(ACT_DELETE, 5'd16, 32'sd0);
    send_op(ACT_DELETE, 5'd15, 32'sd0);
    send_op(ACT_DELETE, 5'd0, 32'sd0);

    // random walk, drifting between empty and full
    grow = 1'b1;
    for (n = 0; n < 250; n++) begin
      if (n % 40 == 0) grow = ~grow;
      sender_calm = (n >= 120 && n < 180);
      if (n == 100) drain_wait();
      c = sb.count;
      if ($urandom_range(99) < 20) begin
        send_op(action_e'($urandom_range(1)), PosW'($urandom_range(31)), pick_value());
      end else if (c == 0 || (c < Capacity && ($urandom_range(99) < (grow ? 70 : 30)))) begin
        send_op(ACT_INSERT, PosW'($urandom_range(c)), pick_value());
      end else begin
        send_op(ACT_DELETE, PosW'($urandom_range(c - 1)), $urandom);
      end
    end
    sender_calm = 1'b0;

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
